// ===== design/frlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frlp_pkg
// Shared types and constants of the flash ring log pointer manager.
// ----------------------------------------------------------------------------
package frlp_pkg;

    localparam int unsigned FLASH_BYTES  = 8388608;
    localparam int unsigned PACKET_BYTES = 14;

    // Usable ring size: the flash size rounded down to whole packets.
    localparam int unsigned CAP_INT    = FLASH_BYTES - (FLASH_BYTES % PACKET_BYTES);
    localparam logic [23:0] CAP_BYTES  = 24'(CAP_INT);
    localparam bit          CAP_ZERO   = (CAP_INT == 0);

    localparam int ALU_W = 25;

    localparam logic OP_STORE = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLAMP,
        S_SUM,
        S_OVER,
        S_POS,
        S_SPLIT,
        S_LEN1,
        S_WRAP,
        S_CNT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             neg;
    } alu_rsp_t;

endpackage

// ===== design/frlp_addsub.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frlp_addsub
// Shared adder/subtractor used by the pointer sequencer for every arithmetic step.
// ----------------------------------------------------------------------------
module frlp_addsub
    import frlp_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ALU_W:0] full;

    // A subtract that goes below zero leaves the top bit set.
    assign full    = {1'b0, req.a} + ({1'b0, req.b} ^ {(ALU_W + 1){req.sub}})
                     + (ALU_W + 1)'(req.sub);
    assign rsp.res = full[ALU_W-1:0];
    assign rsp.neg = req.sub & full[ALU_W];

endmodule

// ===== design/flash_ring_log_pointer_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_ring_log_pointer_manager
// Head, tail and byte count of a circular log in external flash.
// ----------------------------------------------------------------------------
// Usage: one command item enters on the s_ channel (tuser = op, 0 store,
// 1 load; tdata = length). The block answers with one result item on the
// m_ channel giving the granted length, the flash address of the first
// segment, the two segment lengths, the overwrite flag and the new count.
// All arithmetic runs through one shared 25-bit adder/subtractor under a
// small sequencer. Store steps: sum, overwrite, position, split, wrap;
// load steps: clamp, position, split, wrap, count; both end in the final
// step that fills the result register. An access past the ring end adds a
// first-length step, and the wrap step repeats for each further ring size
// that a store spans. s_tready is high only while the sequencer is idle, so
// one command is handled at a time. The result sits in an output register,
// so a new command is accepted while a result still waits; the sequencer
// holds in its final step while the receiver stalls and the register is
// full. Reset empties the log: head, tail and count go to zero.
// ----------------------------------------------------------------------------
module flash_ring_log_pointer_manager
    import frlp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] length
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] granted_length, [38:16] first_address, [54:39] first_length,
    // [70:55] second_length, [71] overwrote, [95:72] stored_total
    output logic [95:0] m_tdata
);

    state_t state_reg, state_next;

    logic        op_reg, op_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] n_reg, n_next;
    logic [22:0] start_reg, start_next;
    logic [ALU_W-1:0] acc_reg, acc_next;
    logic [ALU_W-1:0] sumc_reg, sumc_next;
    logic        over_reg, over_next;
    logic [15:0] len1_reg, len1_next;
    logic [15:0] len2_reg, len2_next;

    logic [22:0] head_reg, head_next;
    logic [22:0] tail_reg, tail_next;
    logic [23:0] count_reg, count_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [95:0] m_tdata_reg, m_tdata_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    frlp_addsub u_addsub (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        len_reg     <= len_next;
        n_reg       <= n_next;
        start_reg   <= start_next;
        acc_reg     <= acc_next;
        sumc_reg    <= sumc_next;
        over_reg    <= over_next;
        len1_reg    <= len1_next;
        len2_reg    <= len2_next;
        m_tdata_reg <= m_tdata_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        len_next      = len_reg;
        n_next        = n_reg;
        start_next    = start_reg;
        acc_next      = acc_reg;
        sumc_next     = sumc_reg;
        over_next     = over_reg;
        len1_next     = len1_reg;
        len2_next     = len2_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_tdata_next  = m_tdata_reg;
        alu_req.a     = 25'(count_reg);
        alu_req.b     = 25'(n_reg);
        alu_req.sub   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next   = s_tuser[0];
                    len_next  = s_tdata;
                    n_next    = s_tdata;
                    over_next = 1'b0;
                    if (CAP_ZERO)
                    begin
                        // Nothing can ever be stored: report all zeros.
                        n_next     = '0;
                        start_next = '0;
                        len1_next  = '0;
                        len2_next  = '0;
                        state_next = S_FIN;
                    end
                    else if (s_tuser[0] == OP_LOAD)
                    begin
                        state_next = S_CLAMP;
                    end
                    else
                    begin
                        state_next = S_SUM;
                    end
                end
            end

            S_CLAMP:
            begin
                alu_req.a   = 25'(count_reg);
                alu_req.b   = 25'(len_reg);
                alu_req.sub = 1'b1;
                if (alu_rsp.neg)
                begin
                    n_next = count_reg[15:0];
                end
                state_next = S_POS;
            end

            S_SUM:
            begin
                alu_req.a  = 25'(count_reg);
                alu_req.b  = 25'(n_reg);
                sumc_next  = alu_rsp.res;
                state_next = S_OVER;
            end

            S_OVER:
            begin
                alu_req.a   = sumc_reg;
                alu_req.b   = 25'(CAP_BYTES);
                alu_req.sub = 1'b1;
                over_next   = ~alu_rsp.neg;
                state_next  = S_POS;
            end

            S_POS:
            begin
                start_next = (op_reg == OP_LOAD) ? head_reg : tail_reg;
                alu_req.a  = (op_reg == OP_LOAD) ? 25'(head_reg) : 25'(tail_reg);
                alu_req.b  = 25'(n_reg);
                acc_next   = alu_rsp.res;
                state_next = S_SPLIT;
            end

            S_SPLIT:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = 25'(CAP_BYTES);
                alu_req.sub = 1'b1;
                if (!alu_rsp.neg)
                begin
                    acc_next = alu_rsp.res;
                end
                // The access runs past the end of the ring when the overshoot
                // is strictly positive; the overshoot is the second segment.
                if (!alu_rsp.neg && (alu_rsp.res != '0))
                begin
                    len2_next  = alu_rsp.res[15:0];
                    state_next = S_LEN1;
                end
                else
                begin
                    len1_next  = n_reg;
                    len2_next  = '0;
                    state_next = S_WRAP;
                end
            end

            S_LEN1:
            begin
                alu_req.a   = 25'(n_reg);
                alu_req.b   = 25'(len2_reg);
                alu_req.sub = 1'b1;
                len1_next   = alu_rsp.res[15:0];
                state_next  = S_WRAP;
            end

            S_WRAP:
            begin
                // Reduce the new pointer below the ring size one subtract at a time.
                alu_req.a   = acc_reg;
                alu_req.b   = 25'(CAP_BYTES);
                alu_req.sub = 1'b1;
                if (!alu_rsp.neg)
                begin
                    acc_next = alu_rsp.res;
                end
                else if (op_reg == OP_LOAD)
                begin
                    head_next  = acc_reg[22:0];
                    state_next = S_CNT;
                end
                else
                begin
                    tail_next = acc_reg[22:0];
                    if (over_reg)
                    begin
                        head_next  = acc_reg[22:0];
                        count_next = CAP_BYTES;
                    end
                    else
                    begin
                        count_next = sumc_reg[23:0];
                    end
                    state_next = S_FIN;
                end
            end

            S_CNT:
            begin
                alu_req.a   = 25'(count_reg);
                alu_req.b   = 25'(n_reg);
                alu_req.sub = 1'b1;
                count_next  = alu_rsp.res[23:0];
                state_next  = S_FIN;
            end

            S_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {count_reg, over_reg, len2_reg, len1_reg,
                                     start_reg, n_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== design/frlp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frlp_checker
// Port-level checks on the result channel of the pointer manager.
// ----------------------------------------------------------------------------
module frlp_checker
    import frlp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    logic [15:0] granted;
    logic [22:0] first_addr;
    logic [15:0] first_len;
    logic [15:0] second_len;
    logic        overwrote;
    logic [23:0] total;

    assign granted    = m_tdata[15:0];
    assign first_addr = m_tdata[38:16];
    assign first_len  = m_tdata[54:39];
    assign second_len = m_tdata[70:55];
    assign overwrote  = m_tdata[71];
    assign total      = m_tdata[95:72];

    // A stalled result item must hold.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> total <= CAP_BYTES)
        else $error("stored count exceeds ring size");

    a_overwrite_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && overwrote |-> total == CAP_BYTES)
        else $error("overwrite did not leave the ring full");

    a_segments: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 16'(first_len + second_len) == granted)
        else $error("segment lengths do not add up to the granted length");

    // A wrapped access must end its first segment exactly at the ring end.
    a_wrap_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && second_len != 16'd0
        |-> 25'(first_addr) + 25'(first_len) == 25'(CAP_BYTES))
        else $error("first segment of a wrapped access misses the ring end");

endmodule

bind flash_ring_log_pointer_manager frlp_checker u_frlp_checker (.*);

// ===== dv/flash_ring_log_pointer_manager_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flash_ring_log_pointer_manager_tb
// Self-checking bench for the ring log pointer manager. Store and load
// commands are driven with random gaps on both streams. A scoreboard keeps
// its own head, tail and byte count and checks every field of each result.
// ----------------------------------------------------------------------------
module flash_ring_log_pointer_manager_tb;
    import frlp_pkg::*;

    localparam int RANDOM_ITEMS = 640;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;

    // Same field order as m_tdata, highest field first.
    typedef struct packed {
        logic [23:0] stored_total;
        logic        overwrote;
        logic [15:0] second_length;
        logic [15:0] first_length;
        logic [22:0] first_address;
        logic [15:0] granted_length;
    } ring_access_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    class ring_pointer_checker;
        logic [22:0]  head_ptr;
        logic [22:0]  tail_ptr;
        logic [23:0]  byte_count;
        ring_access_t pending_accesses[$];
        int           errors;

        function new();
            head_ptr   = '0;
            tail_ptr   = '0;
            byte_count = '0;
            errors     = 0;
        endfunction

        // Works out the result of one accepted command and advances the ring.
        function void note_command(logic op, logic [15:0] length);
            ring_access_t acc;
            int unsigned  cap, start, n, len1, len2;
            bit           over;
            acc = '0;
            cap = CAP_BYTES;
            n   = length;
            if (CAP_ZERO) begin
                pending_accesses.push_back(acc);
                return;
            end
            if (op == OP_STORE) begin
                start = tail_ptr;
                over  = (byte_count + n) >= cap;
                len1  = (start + n > cap) ? cap - start : n;
                len2  = n - len1;
                tail_ptr = 23'((start + n) % cap);
                if (over) begin
                    head_ptr   = tail_ptr;
                    byte_count = 24'(cap);
                end else begin
                    byte_count = 24'(byte_count + n);
                end
                acc.overwrote = over;
            end else begin
                start = head_ptr;
                if (byte_count == 0) begin
                    n = 0;
                end else if (n > byte_count) begin
                    n = byte_count;
                end
                len1 = (start + n > cap) ? cap - start : n;
                len2 = n - len1;
                head_ptr   = 23'((start + n) % cap);
                byte_count = 24'(byte_count - n);
            end
            acc.granted_length = 16'(n);
            acc.first_address  = 23'(start);
            acc.first_length   = 16'(len1);
            acc.second_length  = 16'(len2);
            acc.stored_total   = byte_count;
            pending_accesses.push_back(acc);
        endfunction

        function void compare_field(string field, logic [23:0] want, logic [23:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(logic [95:0] raw);
            ring_access_t want, got;
            got = raw;
            if (pending_accesses.size() == 0) begin
                errors++;
                $display("%0t: unexpected result item, expected none, actual %h",
                         $time, raw);
                return;
            end
            want = pending_accesses.pop_front();
            compare_field("granted_length", want.granted_length, got.granted_length);
            compare_field("first_address", want.first_address, got.first_address);
            compare_field("first_length", want.first_length, got.first_length);
            compare_field("second_length", want.second_length, got.second_length);
            compare_field("overwrote", want.overwrote, got.overwrote);
            compare_field("stored_total", want.stored_total, got.stored_total);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] length
    logic [0:0]  s_tuser;   // [0] op
    logic        m_tvalid;
    logic        m_tready;
    // [15:0] granted_length, [38:16] first_address, [54:39] first_length,
    // [70:55] second_length, [71] overwrote, [95:72] stored_total
    logic [95:0] m_tdata;

    ring_pointer_checker sb;
    bit                  quiet;
    bit                  hold_req;
    int                  cycle_count;

    flash_ring_log_pointer_manager u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
    function automatic int gap_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Lengths lean toward the interesting edges of the ring as it stands now.
    function automatic logic [15:0] pick_length(logic op);
        int unsigned cap, to_end, room, roll;
        cap  = CAP_BYTES;
        roll = $urandom_range(0, 99);
        if (op == OP_STORE) begin
            to_end = cap - sb.tail_ptr;
            room   = cap - sb.byte_count;
            if (roll < 10 && to_end < 65535)
                return 16'(to_end + $urandom_range(0, 1));
            if (roll < 20 && room >= 1 && room <= 65535)
                return 16'(room - $urandom_range(0, 1));
            if (roll < 25 && room == 0)
                return 16'd0;
            if (roll < 65)
                return 16'($urandom_range(60000, 65535));
            if (roll < 80)
                return 16'($urandom_range(0, 255));
            return 16'($urandom_range(0, 65535));
        end
        to_end = cap - sb.head_ptr;
        if (roll < 15 && to_end < 65535)
            return 16'(to_end + $urandom_range(0, 1));
        if (roll < 35 && sb.byte_count < 65535)
            return 16'(sb.byte_count + $urandom_range(0, 1));
        if (roll < 55)
            return 16'hFFFF;
        if (roll < 70)
            return 16'($urandom_range(0, 255));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Offers one command item and returns at the falling edge after it is taken.
    task automatic send_command(input logic op, input logic [15:0] length);
        s_tuser  <= op;
        s_tdata  <= length;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_command(op, length);
        @(negedge clk);
    endtask

    task automatic pause_sender();
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 3) == 0)
                    stall_left = gap_cycles();
            end
        end
    end

    initial
    begin
        logic        op;
        logic [15:0] length;
        mix_t        mix;
        int          store_pct;
        sb          = new();
        quiet       = 1'b0;
        hold_req    = 1'b0;
        cycle_count = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_STORE;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty-log loads, zero-length store, clamping and exact drain.
        send_command(OP_LOAD, 16'd0);
        send_command(OP_LOAD, 16'hFFFF);
        send_command(OP_STORE, 16'd0);
        send_command(OP_STORE, 16'hFFFF);
        send_command(OP_STORE, 16'd1);
        send_command(OP_LOAD, 16'd0);
        send_command(OP_LOAD, 16'd1);
        send_command(OP_LOAD, 16'hFFFF);
        send_command(OP_LOAD, 16'd100);
        pause_sender();
        send_command(OP_STORE, 16'h5555);
        send_command(OP_STORE, 16'hAAAA);
        send_command(OP_LOAD, 16'h00FF);
        send_command(OP_STORE, 16'h8000);
        send_command(OP_LOAD, 16'hFFFF);
        send_command(OP_LOAD, 16'hFFFF);
        send_command(OP_LOAD, 16'd7);

        // The ring only wraps and overwrites after it is filled, so the run
        // opens with a fill stretch and then changes its mix in chunks.
        mix = MIX_FILL;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= 160 && i % 40 == 0) begin
                mix   = mix_t'($urandom_range(0, 2));
                quiet = ($urandom_range(0, 3) == 0);
            end
            if (i == 300)
                hold_req = 1'b1;
            case (mix)
                MIX_FILL:  store_pct = 90;
                MIX_DRAIN: store_pct = 30;
                default:   store_pct = 55;
            endcase
            op     = ($urandom_range(0, 99) < store_pct) ? OP_STORE : OP_LOAD;
            length = pick_length(op);
            send_command(op, length);
            pause_sender();
        end
        s_tvalid <= 1'b0;
        quiet = 1'b1;

        while (sb.pending_accesses.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
